>>> rtl/mwse_pkg.sv
// shared constants and types for the sliding-window sample energy block
`timescale 1ns / 1ps

package mwse_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SQUARE_W   = 31;
  localparam int unsigned TERM_W     = 32;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned WINDOW_DEF = 64;

  localparam logic [SHIFT_W-1:0] SHIFT_RST  = SHIFT_W'(6);
  localparam logic [TERM_W-1:0]  ENERGY_SAT = 32'h7FFF_FFFF;

  typedef logic [TERM_W-1:0] term_t;

  // handshake between the energy front end and the accumulator
  typedef struct packed {
    logic  valid;
    term_t term;
  } term_word_t;

endpackage

>>> rtl/mwse_term.sv
// two-stage energy front end: squares, then saturated sum and shift
`timescale 1ns / 1ps

module mwse_term (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [mwse_pkg::SAMPLE_W-1:0] sample_real_i,
  input  logic signed [mwse_pkg::SAMPLE_W-1:0] sample_imag_i,
  input  logic        [mwse_pkg::SHIFT_W-1:0]  energy_shift_i,
  input  logic                                 take_i,
  output mwse_pkg::term_word_t                 word_o
);

  logic                                valid1_q, valid2_q;
  logic [mwse_pkg::SQUARE_W-1:0]       sq_re_q, sq_im_q;
  mwse_pkg::term_t                     term_q;
  logic signed [2*mwse_pkg::SAMPLE_W-1:0] prod_re, prod_im;
  logic [mwse_pkg::TERM_W-1:0]         sum, sat;
  logic                                adv1, adv2;

  assign adv2       = !valid2_q || take_i;
  assign adv1       = !valid1_q || adv2;
  assign in_stall_o = !adv1;

  assign prod_re = sample_real_i * sample_real_i;
  assign prod_im = sample_imag_i * sample_imag_i;

  assign sum = {1'b0, sq_re_q} + {1'b0, sq_im_q};
  assign sat = sum[mwse_pkg::TERM_W-1] ? mwse_pkg::ENERGY_SAT : sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      if (adv1) valid1_q <= in_valid_i;
      if (adv2) valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      sq_re_q <= prod_re[mwse_pkg::SQUARE_W-1:0];
      sq_im_q <= prod_im[mwse_pkg::SQUARE_W-1:0];
    end
    if (adv2 && valid1_q) begin
      term_q <= sat >> energy_shift_i;
    end
  end

  assign word_o.valid = valid2_q;
  assign word_o.term  = term_q;

endmodule

>>> rtl/mwse_cell.sv
// one cell of the term delay line
`timescale 1ns / 1ps

module mwse_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  mwse_pkg::term_t term_i,
  output mwse_pkg::term_t term_o
);

  mwse_pkg::term_t term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= '0;
    end else if (shift_i) begin
      term_q <= term_i;
    end
  end

  assign term_o = term_q;

endmodule

>>> rtl/moving_window_sample_energy.sv
// top level: sliding-window sum of sample energies
//
//   channel  dir  handshake                  payload
//   in       in   in_valid_i / in_stall_o    sample_real_i, sample_imag_i
//   out      out  out_valid_o / out_stall_i  window_energy_o
//   cfg      in   cfg_valid_i / cfg_ready_o  cfg_energy_shift_i
//
// one word per cycle sustained while the output is not stalled
// squares, saturated shift and accumulate each take one registered stage
// the window is a chain of WINDOW cells shifted once per word, cleared by reset
// a stalled output holds its word; empty stages still fill while it waits
`timescale 1ns / 1ps

module moving_window_sample_energy #(
  parameter int unsigned WINDOW = mwse_pkg::WINDOW_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [mwse_pkg::SAMPLE_W-1:0] sample_real_i,
  input  logic signed [mwse_pkg::SAMPLE_W-1:0] sample_imag_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic        [mwse_pkg::TERM_W-1:0]   window_energy_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [mwse_pkg::SHIFT_W-1:0]  cfg_energy_shift_i
);

  logic [mwse_pkg::SHIFT_W-1:0] shift_q;
  mwse_pkg::term_word_t         word;
  mwse_pkg::term_t              chain [WINDOW+1];
  mwse_pkg::term_t              sum_q, sum_d;
  logic                         out_valid_q;
  logic                         take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= mwse_pkg::SHIFT_RST;
    end else if (cfg_valid_i) begin
      shift_q <= cfg_energy_shift_i;
    end
  end

  mwse_term u_term (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_real_i  (sample_real_i),
    .sample_imag_i  (sample_imag_i),
    .energy_shift_i (shift_q),
    .take_i         (!out_valid_q || !out_stall_i),
    .word_o         (word)
  );

  assign take     = word.valid && (!out_valid_q || !out_stall_i);
  assign chain[0] = word.term;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    mwse_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (take),
      .term_i  (chain[i]),
      .term_o  (chain[i+1])
    );
  end

  assign sum_d = sum_q - chain[WINDOW] + word.term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      if (take) begin
        sum_q       <= sum_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign window_energy_o = sum_q;

endmodule

>>> rtl/mwse_checker.sv
// port-level checks for the sliding-window sample energy block
`timescale 1ns / 1ps

module mwse_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic signed [mwse_pkg::SAMPLE_W-1:0] sample_real_i,
  input logic signed [mwse_pkg::SAMPLE_W-1:0] sample_imag_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic        [mwse_pkg::TERM_W-1:0]   window_energy_o
);

  // stalled input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(sample_real_i)
                                 && $stable(sample_imag_i))
    else $error("input word changed under stall");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(window_energy_o))
    else $error("output word changed under stall");

  // input can only be held off when a finished word is waiting
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // an accepted word reaches the output through the square, term and sum registers while the output is not stalled
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("word not delivered in time");

  // the window sum moves only together with a new output word
  a_sum_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(window_energy_o) |-> out_valid_o)
    else $error("window sum changed without output word");

endmodule

bind moving_window_sample_energy mwse_checker u_mwse_checker (.*);

>>> tb/sv/testbench.sv
// testbench for the sliding-window sample energy block: directed table, then random words
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned WIN         = mwse_pkg::WINDOW_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_WORDS = 100;

  typedef logic signed [mwse_pkg::SAMPLE_W-1:0] sample_t;
  typedef logic [mwse_pkg::SHIFT_W-1:0]         shift_t;

  typedef enum logic {ROW_SAMPLE, ROW_SHIFT} row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    shift_t          shift;
    sample_t         re;
    sample_t         im;
    logic            fixed;
    mwse_pkg::term_t energy;
  } row_t;

  localparam int unsigned ROWS = 19;
  localparam row_t SCRIPT [ROWS] = '{
    '{ROW_SAMPLE, 5'd0,  16'h0000, 16'h0000, 1'b1, 32'h0000_0000},
    '{ROW_SAMPLE, 5'd0,  16'h8000, 16'h8000, 1'b1, 32'h01FF_FFFF},
    '{ROW_SAMPLE, 5'd0,  16'h7FFF, 16'h7FFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, 5'd0,  16'h8000, 16'h0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 5'd0,  16'h0000, 16'h8000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 5'd0,  16'h7FFF, 16'h8000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 5'd0,  16'h8000, 16'h7FFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, 5'd0,  16'hFFFF, 16'hFFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, 5'd0,  16'h0001, 16'h0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 5'd0,  16'h5555, 16'hAAAA, 1'b0, 32'h0},
    '{ROW_SHIFT,  5'd0,  16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 5'd0,  16'h8000, 16'h8000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 5'd0,  16'h7FFF, 16'h7FFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, 5'd0,  16'h8000, 16'h8001, 1'b0, 32'h0},
    '{ROW_SAMPLE, 5'd0,  16'hAAAA, 16'h5555, 1'b0, 32'h0},
    '{ROW_SHIFT,  5'd31, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 5'd0,  16'h8000, 16'h8000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 5'd0,  16'h7FFF, 16'h7FFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, 5'd0,  16'h0001, 16'h0001, 1'b0, 32'h0}
  };

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  sample_t         sample_real_i;
  sample_t         sample_imag_i;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  mwse_pkg::term_t window_energy_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  shift_t          cfg_energy_shift_i;

  mwse_pkg::term_t energy_ring [WIN];
  int unsigned     ring_pos;
  mwse_pkg::term_t running_sum;
  shift_t          shift_now;

  mwse_pkg::term_t energy_q [$];
  mwse_pkg::term_t expected_energy;
  int unsigned     mismatches = 0;
  int unsigned     cycle_count = 0;
  bit              steady;

  moving_window_sample_energy #(
    .WINDOW(WIN)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .sample_real_i      (sample_real_i),
    .sample_imag_i      (sample_imag_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .window_energy_o    (window_energy_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_energy_shift_i (cfg_energy_shift_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic mwse_pkg::term_t next_window_energy(sample_t re, sample_t im);
    longint          power;
    mwse_pkg::term_t term;
    power = longint'(re) * longint'(re) + longint'(im) * longint'(im);
    if (power > longint'(mwse_pkg::ENERGY_SAT)) begin
      power = longint'(mwse_pkg::ENERGY_SAT);
    end
    term = mwse_pkg::term_t'(power) >> shift_now;
    running_sum = running_sum - energy_ring[ring_pos] + term;
    energy_ring[ring_pos] = term;
    ring_pos = (ring_pos + 1) % WIN;
    return running_sum;
  endfunction

  task automatic send_sample(sample_t re, sample_t im, logic fixed,
                             mwse_pkg::term_t fixed_energy);
    mwse_pkg::term_t predicted;
    in_valid_i    <= 1'b1;
    sample_real_i <= re;
    sample_imag_i <= im;
    do @(posedge clk_i); while (in_stall_o);
    predicted = next_window_energy(re, im);
    energy_q.push_back(fixed ? fixed_energy : predicted);
  endtask

  task automatic maybe_gap();
    if (!steady && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (energy_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_shift(shift_t value);
    cfg_valid_i        <= 1'b1;
    cfg_energy_shift_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shift_now = value;
  endtask

  function automatic sample_t pick_part();
    sample_t corners [5] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001, 16'shFFFF};
    if ($urandom_range(0, 7) == 0) begin
      return corners[$urandom_range(0, 4)];
    end
    return sample_t'($urandom());
  endfunction

  // random output stalls outside steady phases; received words checked against the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !steady && ($urandom_range(0, 99) < 20);
      if (out_valid_o && !out_stall_i) begin
        if (energy_q.size() == 0) begin
          $display("%0t: window_energy expected none, got %h", $time, window_energy_o);
          mismatches++;
        end else begin
          expected_energy = energy_q.pop_front();
          if (window_energy_o !== expected_energy) begin
            $display("%0t: window_energy expected %h, got %h", $time, expected_energy,
                     window_energy_o);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    shift_t  phase_shift;
    sample_t re;
    sample_t im;
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    sample_real_i      = '0;
    sample_imag_i      = '0;
    cfg_valid_i        = 1'b0;
    cfg_energy_shift_i = '0;
    steady             = 1'b0;
    for (int k = 0; k < WIN; k++) begin
      energy_ring[k] = '0;
    end
    ring_pos    = 0;
    running_sum = '0;
    shift_now   = mwse_pkg::SHIFT_RST;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < ROWS; r++) begin
      if (SCRIPT[r].kind == ROW_SHIFT) begin
        drain();
        write_shift(SCRIPT[r].shift);
      end else begin
        maybe_gap();
        send_sample(SCRIPT[r].re, SCRIPT[r].im, SCRIPT[r].fixed, SCRIPT[r].energy);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      unique case (p)
        0: phase_shift = 5'd0;
        1: phase_shift = 5'd31;
        3: phase_shift = 5'd1;
        5: phase_shift = mwse_pkg::SHIFT_RST;
        default: phase_shift = shift_t'($urandom_range(0, 31));
      endcase
      drain();
      write_shift(phase_shift);
      steady = (p == 2);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // saturating corner about one word in sixteen
        if ($urandom_range(0, 15) == 0) begin
          re = 16'sh8000;
          im = 16'sh8000;
        end else begin
          re = pick_part();
          im = pick_part();
        end
        maybe_gap();
        send_sample(re, im, 1'b0, '0);
      end
      steady = 1'b0;
    end

    in_valid_i <= 1'b0;
    while (energy_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
